>>> rtl/ethernet_rx_frame_filter_defines.svh
// Assertion macros shared by the frame filter checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ETHERNET_RX_FRAME_FILTER_DEFINES_SVH
`define ETHERNET_RX_FRAME_FILTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ERFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame filter check failed");

// Consequent must hold in the cycle after the antecedent.
`define ERFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame filter check failed");

`endif

>>> rtl/erff_pkg.sv
// Types, constants and the bytewise CRC-32 update for the receive frame filter.
// Depends on nothing.
package erff_pkg;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_ACCEPTED = 2'd0;
    localparam status_t STATUS_ADDR_MISS = 2'd1;
    localparam status_t STATUS_CRC_ERROR = 2'd2;
    localparam status_t STATUS_RUNT = 2'd3;

    localparam int ADDR_BYTES = 6;
    localparam int TYPE_HI_INDEX = 12;
    localparam int TYPE_LO_INDEX = 13;
    localparam int HEADER_BYTES = 14;
    localparam int TRAILER_BYTES = 4;
    localparam int MIN_FRAME = HEADER_BYTES + TRAILER_BYTES;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
    localparam logic [7:0] BROADCAST_BYTE = 8'hFF;

    // Reflected CRC-32 over one byte, least significant bit first.
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/ethernet_rx_frame_filter.sv
// Rx Ethernet frame filter: address match, type and length capture, CRC-32 and runt checks.
// A result is registered and shown in the cycle after the transfer of the final byte.
// Throughput: one byte per cycle unless a result is stalled; bytewise CRC is combinational.
// A waiting result holds the input only while it is stalled on the output side.
// Reset (rst_n low, asynchronous) clears the frame state, the local address and
// the output valid; frame state also returns to its reset values after each final byte.
module ethernet_rx_frame_filter #(
    parameter int LENGTH_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [47:0]       cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        frame_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output erff_pkg::status_t status,
    output logic              is_broadcast,
    output logic [15:0]       ether_type,
    output logic [15:0]       payload_length
);
    import erff_pkg::*;

    localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};
    localparam logic [LENGTH_BITS-1:0] IDX_ADDR_END = LENGTH_BITS'(ADDR_BYTES);
    localparam logic [LENGTH_BITS-1:0] IDX_TYPE_HI = LENGTH_BITS'(TYPE_HI_INDEX);
    localparam logic [LENGTH_BITS-1:0] IDX_TYPE_LO = LENGTH_BITS'(TYPE_LO_INDEX);
    localparam logic [LENGTH_BITS-1:0] IDX_HEADER = LENGTH_BITS'(HEADER_BYTES);
    localparam logic [LENGTH_BITS-1:0] IDX_MIN_FRAME = LENGTH_BITS'(MIN_FRAME);

    logic [47:0]            local_address_reg;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic                   bcast_reg, bcast_next;
    logic                   local_reg, local_next;
    logic [15:0]            type_reg, type_next;
    logic [31:0]            crc_reg, crc_next;
    logic [7:0]             trail_reg [TRAILER_BYTES];
    logic [7:0]             trail_next [TRAILER_BYTES];

    logic                   out_valid_reg, out_valid_next;
    status_t                status_reg, status_next;
    logic                   bcast_out_reg, bcast_out_next;
    logic [15:0]            type_out_reg, type_out_next;
    logic [15:0]            length_out_reg, length_out_next;

    logic                   accept;
    logic [47:0]            addr_shift;
    logic [LENGTH_BITS-1:0] length_calc;
    logic [31:0]            trailer_word;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;

    // The wanted address byte sits in bits 47..40 after shifting by the byte index.
    assign addr_shift = local_address_reg << {count_reg[2:0], 3'b000};

    always_comb
    begin
        count_next = count_reg;
        bcast_next = bcast_reg;
        local_next = local_reg;
        type_next = type_reg;
        crc_next = crc_reg;
        trail_next = trail_reg;
        status_next = status_reg;
        bcast_out_next = bcast_out_reg;
        type_out_next = type_out_reg;
        length_out_next = length_out_reg;
        length_calc = '0;
        trailer_word = '0;
        out_valid_next = out_ready ? 1'b0 : out_valid_reg;

        if (accept)
        begin
            if (count_reg < IDX_ADDR_END)
            begin
                if (frame_byte != BROADCAST_BYTE)
                begin
                    bcast_next = 1'b0;
                end
                if (frame_byte != addr_shift[47:40])
                begin
                    local_next = 1'b0;
                end
            end
            else if (count_reg == IDX_TYPE_HI)
            begin
                type_next[15:8] = frame_byte;
            end
            else if (count_reg == IDX_TYPE_LO)
            begin
                type_next[7:0] = frame_byte;
            end

            // Header bytes bypass the trailer delay; only bytes pushed out of it reach the CRC.
            if (count_reg >= IDX_HEADER)
            begin
                if (count_reg >= IDX_MIN_FRAME)
                begin
                    crc_next = crc_byte(crc_reg, trail_reg[0]);
                end
                for (int i = 0; i < TRAILER_BYTES - 1; i++)
                begin
                    trail_next[i] = trail_reg[i+1];
                end
                trail_next[TRAILER_BYTES-1] = frame_byte;
            end

            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 1'b1;
            end

            if (last_byte)
            begin
                out_valid_next = 1'b1;
                trailer_word = {trail_next[3], trail_next[2], trail_next[1], trail_next[0]};
                length_calc = count_next - IDX_MIN_FRAME;
                if (count_next < IDX_MIN_FRAME)
                begin
                    status_next = STATUS_RUNT;
                    bcast_out_next = 1'b0;
                    type_out_next = '0;
                    length_out_next = '0;
                end
                else
                begin
                    if (!bcast_next && !local_next)
                    begin
                        status_next = STATUS_ADDR_MISS;
                    end
                    else if ((crc_next ^ CRC_INIT) != trailer_word)
                    begin
                        status_next = STATUS_CRC_ERROR;
                    end
                    else
                    begin
                        status_next = STATUS_ACCEPTED;
                    end
                    bcast_out_next = bcast_next;
                    type_out_next = type_next;
                    length_out_next = 16'(length_calc);
                end

                count_next = '0;
                bcast_next = 1'b1;
                local_next = 1'b1;
                type_next = '0;
                crc_next = CRC_INIT;
                for (int i = 0; i < TRAILER_BYTES; i++)
                begin
                    trail_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_address_reg <= '0;
            count_reg <= '0;
            bcast_reg <= 1'b1;
            local_reg <= 1'b1;
            type_reg <= '0;
            crc_reg <= CRC_INIT;
            for (int i = 0; i < TRAILER_BYTES; i++)
            begin
                trail_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                local_address_reg <= cfg_data;
            end
            count_reg <= count_next;
            bcast_reg <= bcast_next;
            local_reg <= local_next;
            type_reg <= type_next;
            crc_reg <= crc_next;
            trail_reg <= trail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        bcast_out_reg <= bcast_out_next;
        type_out_reg <= type_out_next;
        length_out_reg <= length_out_next;
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign is_broadcast = bcast_out_reg;
    assign ether_type = type_out_reg;
    assign payload_length = length_out_reg;

endmodule

>>> rtl/erff_checker.sv
// Port-level assertions for the receive frame filter, bound to its top level.
// Depends on erff_pkg and ethernet_rx_frame_filter_defines.svh.
`include "ethernet_rx_frame_filter_defines.svh"

module erff_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              last_byte,
    input logic              out_valid,
    input logic              out_ready,
    input erff_pkg::status_t status,
    input logic              is_broadcast,
    input logic [15:0]       ether_type,
    input logic [15:0]       payload_length
);
    import erff_pkg::*;

    // A stalled result keeps its status.
    `ERFF_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))

    // A runt frame reports no header fields.
    `ERFF_ASSERT_SAME(a_runt_clean, clk, rst_n, out_valid && status == STATUS_RUNT, !is_broadcast && ether_type == 16'd0 && payload_length == 16'd0)

    // A transfer of a non-final byte never produces a result.
    `ERFF_ASSERT_NEXT(a_no_mid_result, clk, rst_n, in_valid && in_ready && !last_byte, !out_valid)

    // Every final byte yields a result in the following cycle.
    `ERFF_ASSERT_NEXT(a_final_result, clk, rst_n, in_valid && in_ready && last_byte, out_valid)

    // The input is held off only while a result waits.
    `ERFF_ASSERT_SAME(a_ready_rule, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready))

endmodule

bind ethernet_rx_frame_filter erff_checker u_erff_checker (.*);
